// File: src/mrd_pkg.sv
// Shared types and constants of the masked record directory.
`default_nettype none
package mrd_pkg;

   localparam int ENTRIES_DEF    = 1024;
   localparam int MAX_META_WORDS = 8;
   localparam int QUEUE_DEPTH    = 2;
   localparam int KEY_W          = 11;
   localparam int ADDR_W         = 48;
   localparam int WORD_W         = 32;
   localparam int IDX_W          = 3;
   localparam int WCNT_W         = $clog2(MAX_META_WORDS + 1);
   localparam int CSR_W          = 4;
   localparam int CSR_RESET      = 4;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_SEARCH = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NOMATCH = 2'd2,
      ST_BADKEY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_SEARCH,
      BS_READ
   } bstate_type;

   typedef logic [MAX_META_WORDS-1:0][WORD_W-1:0] word_vec_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_W-1:0]    key;
      logic                use_mask;
      logic [ADDR_W-1:0]   addr;
      logic [ADDR_W-1:0]   len;
      logic [WCNT_W-1:0]   n;
      word_vec_type        words;
      word_vec_type        masks;
   } cmd_type;

endpackage
`default_nettype wire

// File: src/mrd_front.sv
// Front end: gathers metadata and mask words and issues complete commands.
`default_nettype none
module mrd_front
   import mrd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [2:0]          req_word_index,
   input  wire logic                req_last_word,
   input  wire logic [31:0]         req_meta_value,
   input  wire logic [31:0]         req_mask_value,
   input  wire logic                req_use_mask,
   input  wire logic [10:0]         req_start_key,
   input  wire logic [47:0]         req_entry_address,
   input  wire logic [47:0]         req_entry_length,
   input  wire logic                csr_write,
   input  wire logic [3:0]          csr_wdata,
   input  wire logic                q_full,
   output logic                     q_push,
   output cmd_type                  q_cmd
);

   word_vec_type       words_ff, words_in, masks_ff, masks_in;
   logic [CSR_W-1:0]   csr_ff, csr_in;
   logic [WCNT_W-1:0]  n_clamped;
   logic               accept;
   op_type             op;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_opcode);

   always_comb begin
      csr_in = csr_write ? csr_wdata : csr_ff;
      if (csr_ff == '0) begin
         n_clamped = WCNT_W'(1);
      end else if (32'(csr_ff) > MAX_META_WORDS) begin
         n_clamped = WCNT_W'(MAX_META_WORDS);
      end else begin
         n_clamped = WCNT_W'(csr_ff);
      end
   end

   always_comb begin
      words_in = words_ff;
      masks_in = masks_ff;
      if (accept && (op == OP_APPEND || op == OP_SEARCH)) begin
         for (int j = 0; j < MAX_META_WORDS; j++) begin
            if (32'(req_word_index) == j) begin
               words_in[j] = req_meta_value;
               if (op == OP_SEARCH) begin
                  masks_in[j] = req_mask_value;
               end
            end
         end
      end
      q_push         = accept && req_last_word && (op != OP_NONE);
      q_cmd.op       = op;
      q_cmd.key      = req_start_key;
      q_cmd.use_mask = req_use_mask;
      q_cmd.addr     = req_entry_address;
      q_cmd.len      = req_entry_length;
      q_cmd.n        = n_clamped;
      q_cmd.words    = words_in;
      q_cmd.masks    = masks_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= '0;
         masks_ff <= '0;
         csr_ff   <= CSR_W'(CSR_RESET);
      end else begin
         words_ff <= words_in;
         masks_ff <= masks_in;
         csr_ff   <= csr_in;
      end
   end

endmodule
`default_nettype wire

// File: src/mrd_queue.sv
// Short command queue between the front end and the execution back end.
`default_nettype none
module mrd_queue
   import mrd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   output logic         empty,
   input  wire logic    pop,
   output cmd_type      head_cmd
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = slots_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (32'(wr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (32'(rd_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: src/mrd_back.sv
// Back end: directory memories, search walk, read-out and response register.
`default_nettype none
module mrd_back
   import mrd_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_empty,
   input  wire cmd_type       q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [10:0]        rsp_record_key,
   output logic [47:0]        rsp_found_address,
   output logic [47:0]        rsp_found_length,
   output logic [31:0]        rsp_read_word,
   output logic [2:0]         rsp_read_index,
   output logic               rsp_last_result
);

   localparam int IW   = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CMPW = ((CW > KEY_W) ? CW : KEY_W) + 1;

   logic [ADDR_W-1:0]   addr_mem [ENTRIES];
   logic [ADDR_W-1:0]   len_mem  [ENTRIES];
   word_vec_type        meta_mem [ENTRIES];

   bstate_type          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CW-1:0]       used_ff, used_in, row_ff, row_in, chk_row_ff, chk_row_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]    word_ff, word_in;
   logic [ADDR_W-1:0]   addr_q_ff, len_q_ff;
   word_vec_type        meta_q_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, r_status;
   logic [KEY_W-1:0]    rsp_key_ff, r_key;
   logic [ADDR_W-1:0]   rsp_addr_ff, r_addr, rsp_len_ff, r_len;
   logic [WORD_W-1:0]   rsp_word_ff, r_word;
   logic [IDX_W-1:0]    rsp_idx_ff, r_idx;
   logic                rsp_last_ff, r_last;

   logic                free, load, rd_en, wr_en, hit, last_word;
   logic [IW-1:0]       rd_idx;
   logic [CMPW-1:0]     key_ext, used_ext;

   assign free     = !rsp_valid_ff || !rsp_stall;
   assign key_ext  = CMPW'(q_cmd.key);
   assign used_ext = CMPW'(used_ff);

   // Masked compare of the fetched row against the criteria.
   always_comb begin
      logic [WORD_W-1:0] mk;
      hit = 1'b1;
      for (int j = 0; j < MAX_META_WORDS; j++) begin
         mk = cmd_ff.use_mask ? cmd_ff.masks[j] : '1;
         if (j < 32'(cmd_ff.n) && ((cmd_ff.words[j] & mk) != (meta_q_ff[j] & mk))) begin
            hit = 1'b0;
         end
      end
   end

   assign last_word = ((WCNT_W'(word_ff) + WCNT_W'(1)) == cmd_ff.n);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      used_in      = used_ff;
      row_in       = row_ff;
      chk_valid_in = 1'b0;
      chk_row_in   = chk_row_ff;
      word_in      = word_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_idx       = row_ff[IW-1:0];
      wr_en        = 1'b0;
      load         = 1'b0;
      r_status     = ST_OK;
      r_key        = '0;
      r_addr       = '0;
      r_len        = '0;
      r_word       = '0;
      r_idx        = '0;
      r_last       = 1'b1;
      unique case (state_ff)
         BS_IDLE: begin
            if (!q_empty && free) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               unique case (q_cmd.op)
                  OP_APPEND: begin
                     load = 1'b1;
                     if (used_ff == CW'(ENTRIES)) begin
                        r_status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        used_in = used_ff + CW'(1);
                        r_key   = KEY_W'(used_ext + CMPW'(1));
                     end
                  end
                  OP_SEARCH: begin
                     if (key_ext > used_ext) begin
                        load     = 1'b1;
                        r_status = ST_BADKEY;
                     end else begin
                        row_in   = CW'(key_ext);
                        state_in = BS_SEARCH;
                     end
                  end
                  OP_READ: begin
                     if (q_cmd.key == '0 || key_ext > used_ext) begin
                        load     = 1'b1;
                        r_status = ST_BADKEY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_idx   = IW'(key_ext - CMPW'(1));
                        word_in  = '0;
                        state_in = BS_READ;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         BS_SEARCH: begin
            if (chk_valid_ff && hit) begin
               load     = 1'b1;
               r_key    = KEY_W'(CMPW'(chk_row_ff) + CMPW'(1));
               r_addr   = addr_q_ff;
               r_len    = len_q_ff;
               state_in = BS_IDLE;
            end else if (row_ff >= used_ff) begin
               load     = 1'b1;
               r_status = ST_NOMATCH;
               state_in = BS_IDLE;
            end else begin
               rd_en        = 1'b1;
               rd_idx       = row_ff[IW-1:0];
               chk_valid_in = 1'b1;
               chk_row_in   = row_ff;
               row_in       = row_ff + CW'(1);
            end
         end
         BS_READ: begin
            if (free) begin
               load   = 1'b1;
               r_key  = cmd_ff.key;
               r_addr = addr_q_ff;
               r_len  = len_q_ff;
               r_word = meta_q_ff[word_ff];
               r_idx  = word_ff;
               r_last = last_word;
               if (last_word) begin
                  state_in = BS_IDLE;
               end else begin
                  word_in = word_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_mem[used_ff[IW-1:0]] <= q_cmd.addr;
         len_mem[used_ff[IW-1:0]]  <= q_cmd.len;
         meta_mem[used_ff[IW-1:0]] <= q_cmd.words;
      end
      if (rd_en) begin
         addr_q_ff <= addr_mem[rd_idx];
         len_q_ff  <= len_mem[rd_idx];
         meta_q_ff <= meta_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      cmd_in_hold: begin
         cmd_ff     <= cmd_in;
         row_ff     <= row_in;
         chk_row_ff <= chk_row_in;
         word_ff    <= word_in;
      end
      if (load) begin
         rsp_status_ff <= r_status;
         rsp_key_ff    <= r_key;
         rsp_addr_ff   <= r_addr;
         rsp_len_ff    <= r_len;
         rsp_word_ff   <= r_word;
         rsp_idx_ff    <= r_idx;
         rsp_last_ff   <= r_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         used_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_record_key    = rsp_key_ff;
   assign rsp_found_address = rsp_addr_ff;
   assign rsp_found_length  = rsp_len_ff;
   assign rsp_read_word     = rsp_word_ff;
   assign rsp_read_index    = rsp_idx_ff;
   assign rsp_last_result   = rsp_last_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(ENTRIES))
      else $error("directory occupancy beyond capacity");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> used_ff == CW'(ENTRIES))
      else $error("full status while space remains");

   a_partial_only_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_status_ff == ST_OK && state_ff == BS_READ))
      else $error("non-final response outside a read");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BS_IDLE) |-> !q_pop)
      else $error("command taken while another is running");

endmodule
`default_nettype wire

// File: src/masked_record_directory_top.sv
// Top level of the masked record directory.
`default_nettype none
//
//   Channel   Direction  Handshake              Carries
//   req_*     in         req_valid / req_stall  one metadata or criteria word, or a read
//   rsp_*     out        rsp_valid / rsp_stall  status, record number, entry data
//   csr_*     in         csr_write              meta_words (metadata words per entry)
//
// A request is taken whenever the two-entry command queue has room. Append and
// lookups with a bad key answer in the cycle after the back end takes the command.
// A search walks one entry per cycle through the directory memories, from the
// start key up to the occupancy, which never exceeds ENTRIES. A read returns
// meta_words responses (clamped to 1 to 8), one per cycle when the response side
// does not stall. Reset empties the directory and clears the pending words; the
// entry memories need no clearing pass.
module masked_record_directory_top
   import mrd_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_opcode,
   input  wire logic [2:0]    req_word_index,
   input  wire logic          req_last_word,
   input  wire logic [31:0]   req_meta_value,
   input  wire logic [31:0]   req_mask_value,
   input  wire logic          req_use_mask,
   input  wire logic [10:0]   req_start_key,
   input  wire logic [47:0]   req_entry_address,
   input  wire logic [47:0]   req_entry_length,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [10:0]        rsp_record_key,
   output logic [47:0]        rsp_found_address,
   output logic [47:0]        rsp_found_length,
   output logic [31:0]        rsp_read_word,
   output logic [2:0]         rsp_read_index,
   output logic               rsp_last_result,
   input  wire logic          csr_write,
   input  wire logic [3:0]    csr_wdata
);

   // Commands carry a snapshot of the gathered words, so the front end may
   // collect the next request's words while a search is still walking.
   cmd_type   push_cmd, head_cmd;
   logic      q_push, q_full, q_empty, q_pop;

   mrd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_word_index    (req_word_index),
      .req_last_word     (req_last_word),
      .req_meta_value    (req_meta_value),
      .req_mask_value    (req_mask_value),
      .req_use_mask      (req_use_mask),
      .req_start_key     (req_start_key),
      .req_entry_address (req_entry_address),
      .req_entry_length  (req_entry_length),
      .csr_write         (csr_write),
      .csr_wdata         (csr_wdata),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   mrd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .empty    (q_empty),
      .pop      (q_pop),
      .head_cmd (head_cmd)
   );

   // The back end owns the directory and the response register.
   mrd_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_cmd             (head_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_record_key    (rsp_record_key),
      .rsp_found_address (rsp_found_address),
      .rsp_found_length  (rsp_found_length),
      .rsp_read_word     (rsp_read_word),
      .rsp_read_index    (rsp_read_index),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
`default_nettype wire
